// File: sv/triangle_tangent_accumulator_unit_macros.svh
// ----------------------------------------------------------------------------
// Triangle tangent accumulator assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_ACCUMULATOR_UNIT_MACROS_SVH
`define TRIANGLE_TANGENT_ACCUMULATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define TTACC_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ttacc check failed");
`define TTACC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ttacc check failed");
`else
`define TTACC_ASSERT_SAME(lbl, ante, cons)
`define TTACC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: sv/ttacc_pkg.sv
// ----------------------------------------------------------------------------
// Triangle tangent accumulator package
// Widths, codes and shared types of the tangent accumulator.
// ----------------------------------------------------------------------------
package ttacc_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int IDX_W   = 6;
   localparam int FIELD_W = 16;
   localparam int DIFF_W  = FIELD_W + 1;
   localparam int MUL_W   = 25;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int TERM_W  = 2 * DIFF_W + 1;
   localparam int MAG_W   = TERM_W - 1;
   localparam int ACC_W   = 24;
   localparam int Q_W     = 24;
   localparam int NUM_W   = 52;
   localparam int DEN_W   = MAG_W;
   localparam int SUM_W   = 48;
   localparam int RAD_W   = 62;
   localparam int ROOT_W  = RAD_W / 2;
   localparam int NVEC    = 6;
   localparam int WORD_W  = NVEC * ACC_W;

   localparam int DIV_SHIFT  = 16;
   localparam int SQRT_SHIFT = 14;
   localparam int UNIT_SHIFT = 21;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic [Q_W-1:0] Q_HALF = {1'b1, {(Q_W-1){1'b0}}};
   localparam logic [FIELD_W-1:0] UNIT_Q14 = 16'd16384;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_TMUL1, ST_TMUL2, ST_TSUB, ST_TDIV, ST_ARD, ST_AWR, ST_TDONE,
      ST_RRD, ST_RLOAD, ST_NSQ, ST_NCHK, ST_NSQRT, ST_NDGO, ST_NDIV, ST_RDONE
   } state_type;

   typedef struct packed {
      logic           done;
      logic           ovf;
      logic [Q_W-1:0] q;
   } div_rsp_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_rsp_type;

endpackage

// File: sv/triangle_tangent_accumulator_unit.sv
// ----------------------------------------------------------------------------
// Triangle tangent accumulator
// Per-vertex tangent/bitangent sums in one entry memory, fed by triangles.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  request   start / busy       req_opcode, req_vertex_index, req_pos_*, req_tex_*
//  response  rsp_valid strobe   rsp_result_kind, rsp_out_index, rsp_tangent_*,
//                               rsp_bitangent_*, rsp_degenerate, rsp_saturated
//
//  Held corner and clear words are taken without leaving idle. A triangle
//  uses 14 shared multiplies, six divides and 3 memory read-modify-writes,
//  less when degenerate. A read uses per vector 3 squares, a square root and
//  three divides, less for a zero vector. Response words cannot be stalled.
//  Reset clears all entries at once through per-entry valid bits.
// ----------------------------------------------------------------------------
`include "triangle_tangent_accumulator_unit_macros.svh"

module triangle_tangent_accumulator_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [5:0]         req_vertex_index,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_pos_z,
   input  logic signed [15:0] req_tex_u,
   input  logic signed [15:0] req_tex_v,
   output logic               rsp_valid,
   output logic               rsp_result_kind,
   output logic [5:0]         rsp_out_index,
   output logic signed [15:0] rsp_tangent_x,
   output logic signed [15:0] rsp_tangent_y,
   output logic signed [15:0] rsp_tangent_z,
   output logic signed [15:0] rsp_bitangent_x,
   output logic signed [15:0] rsp_bitangent_y,
   output logic signed [15:0] rsp_bitangent_z,
   output logic               rsp_degenerate,
   output logic               rsp_saturated
);
   localparam int FW = ttacc_pkg::FIELD_W;
   localparam int DW = ttacc_pkg::DIFF_W;
   localparam int AW = ttacc_pkg::ACC_W;

   ttacc_pkg::state_type state_ff, state_in;

   logic [1:0]                        cnt_ff;
   logic [ttacc_pkg::MAX_VERTICES-1:0] valid_ff;
   logic                              rsp_valid_ff;

   logic signed [FW-1:0] held_pos_ff [2][3];
   logic signed [FW-1:0] held_tex_ff [2][2];
   logic [ttacc_pkg::IDX_W-1:0] held_idx_ff [2];
   logic [ttacc_pkg::IDX_W-1:0] corner_ff [3];
   logic [ttacc_pkg::IDX_W-1:0] idx_ff;
   logic signed [DW-1:0] e1_ff [3];
   logic signed [DW-1:0] e2_ff [3];
   logic signed [DW-1:0] du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic [2:0] t_ff;
   logic [1:0] k_ff;
   logic       g_ff;
   logic [1:0] j_ff;
   logic [1:0] a_ff;
   logic signed [ttacc_pkg::PROD_W-1:0] prod_ff, first_ff;
   logic signed [ttacc_pkg::TERM_W-1:0] det_ff;
   logic       neg_ff;
   logic       sat_ff;
   logic       degen_ff;
   logic signed [AW-1:0] q_ff [ttacc_pkg::NVEC];
   logic signed [AW-1:0] v_ff [ttacc_pkg::NVEC];
   logic signed [FW-1:0] nout_ff [ttacc_pkg::NVEC];
   logic [ttacc_pkg::SUM_W-1:0]  s_ff;
   logic [ttacc_pkg::ROOT_W-1:0] r_ff;

   logic [ttacc_pkg::WORD_W-1:0] mem [ttacc_pkg::MAX_VERTICES];
   logic [ttacc_pkg::WORD_W-1:0] rdata_ff;
   logic                         rvalid_ff;

   logic rsp_kind_ff, rsp_degen_ff, rsp_sat_ff;
   logic [ttacc_pkg::IDX_W-1:0] rsp_index_ff;
   logic signed [FW-1:0] rsp_vec_ff [ttacc_pkg::NVEC];

   logic accept;
   logic mem_rd_en, mem_wr_en;
   logic [ttacc_pkg::IDX_W-1:0] rd_addr;
   logic div_start, sqrt_start;
   logic [ttacc_pkg::NUM_W-1:0] div_num;
   logic [ttacc_pkg::DEN_W-1:0] div_den;
   logic signed [ttacc_pkg::MUL_W-1:0] mul_a, mul_b;
   ttacc_pkg::div_rsp_type  div_rsp;
   ttacc_pkg::sqrt_rsp_type sqrt_rsp;

   logic [1:0] ax;
   logic [2:0] sq_sel, nsel;
   logic [AW-1:0] sq_mag, nv_mag;
   logic signed [ttacc_pkg::TERM_W-1:0] diff;
   logic [ttacc_pkg::MAG_W-1:0] diff_mag, det_mag;
   logic signed [AW-1:0] tri_q;
   logic                 tri_clip;
   logic [ttacc_pkg::Q_W-1:0] div_neg_q;
   logic [FW-1:0] n_mag;
   logic signed [FW-1:0] norm_q;
   logic [ttacc_pkg::WORD_W-1:0] acc_word;
   logic [ttacc_pkg::NVEC-1:0] acc_clip;

   assign accept = start && !busy;

   // --- datapath helpers ---
   assign ax     = (t_ff < 3'd4) ? 2'(t_ff - 3'd1) : 2'(t_ff - 3'd4);
   assign sq_sel = (g_ff ? 3'd3 : 3'd0) + ((j_ff == 2'd3) ? 3'd0 : 3'(j_ff));
   assign nsel   = (g_ff ? 3'd3 : 3'd0) + 3'(a_ff);
   assign sq_mag = v_ff[sq_sel][AW-1] ? AW'(-v_ff[sq_sel]) : AW'(v_ff[sq_sel]);
   assign nv_mag = v_ff[nsel][AW-1] ? AW'(-v_ff[nsel]) : AW'(v_ff[nsel]);

   assign diff     = ttacc_pkg::TERM_W'(first_ff) - ttacc_pkg::TERM_W'(prod_ff);
   assign diff_mag = diff[ttacc_pkg::TERM_W-1] ? ttacc_pkg::MAG_W'(-diff)
                                               : ttacc_pkg::MAG_W'(diff);
   assign det_mag  = det_ff[ttacc_pkg::TERM_W-1] ? ttacc_pkg::MAG_W'(-det_ff)
                                                 : ttacc_pkg::MAG_W'(det_ff);

   assign div_neg_q = (~div_rsp.q) + ttacc_pkg::Q_W'(1);

   always_comb begin
      if (!neg_ff) begin
         tri_clip = div_rsp.ovf || div_rsp.q[ttacc_pkg::Q_W-1];
         tri_q    = tri_clip ? ttacc_pkg::ACC_MAX : $signed(div_rsp.q);
      end else begin
         tri_clip = div_rsp.ovf || (div_rsp.q > ttacc_pkg::Q_HALF);
         tri_q    = tri_clip ? ttacc_pkg::ACC_MIN : $signed(div_neg_q);
      end
   end

   always_comb begin
      if (div_rsp.ovf || div_rsp.q > ttacc_pkg::Q_W'(ttacc_pkg::UNIT_Q14)) begin
         n_mag = ttacc_pkg::UNIT_Q14;
      end else begin
         n_mag = div_rsp.q[FW-1:0];
      end
      norm_q = v_ff[nsel][AW-1] ? $signed(-n_mag) : $signed(n_mag);
   end

   always_comb begin
      logic signed [AW-1:0] old;
      logic signed [AW:0]   sum;
      for (int s = 0; s < ttacc_pkg::NVEC; s++) begin
         old = rvalid_ff ? $signed(rdata_ff[s*AW +: AW]) : '0;
         sum = (AW+1)'(old) + (AW+1)'(q_ff[s]);
         acc_clip[s] = sum[AW] ^ sum[AW-1];
         if (acc_clip[s]) begin
            acc_word[s*AW +: AW] = sum[AW] ? ttacc_pkg::ACC_MIN : ttacc_pkg::ACC_MAX;
         end else begin
            acc_word[s*AW +: AW] = sum[AW-1:0];
         end
      end
   end

   // --- next state ---
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ttacc_pkg::ST_IDLE: begin
            if (accept && req_opcode == ttacc_pkg::OP_READ) begin
               state_in = ttacc_pkg::ST_RRD;
            end else if (accept && req_opcode == ttacc_pkg::OP_ADD && cnt_ff == 2'd2) begin
               state_in = ttacc_pkg::ST_TMUL1;
            end
         end
         ttacc_pkg::ST_TMUL1: state_in = ttacc_pkg::ST_TMUL2;
         ttacc_pkg::ST_TMUL2: state_in = ttacc_pkg::ST_TSUB;
         ttacc_pkg::ST_TSUB: begin
            priority if (t_ff == 3'd0 && diff == '0) state_in = ttacc_pkg::ST_TDONE;
            else if (t_ff == 3'd0)                   state_in = ttacc_pkg::ST_TMUL1;
            else                                     state_in = ttacc_pkg::ST_TDIV;
         end
         ttacc_pkg::ST_TDIV: begin
            if (div_rsp.done) begin
               state_in = (t_ff == 3'd6) ? ttacc_pkg::ST_ARD : ttacc_pkg::ST_TMUL1;
            end
         end
         ttacc_pkg::ST_ARD: state_in = ttacc_pkg::ST_AWR;
         ttacc_pkg::ST_AWR: begin
            state_in = (k_ff == 2'd2) ? ttacc_pkg::ST_TDONE : ttacc_pkg::ST_ARD;
         end
         ttacc_pkg::ST_TDONE: state_in = ttacc_pkg::ST_IDLE;
         ttacc_pkg::ST_RRD:   state_in = ttacc_pkg::ST_RLOAD;
         ttacc_pkg::ST_RLOAD: state_in = ttacc_pkg::ST_NSQ;
         ttacc_pkg::ST_NSQ: begin
            if (j_ff == 2'd3) state_in = ttacc_pkg::ST_NCHK;
         end
         ttacc_pkg::ST_NCHK: begin
            priority if (s_ff != '0) state_in = ttacc_pkg::ST_NSQRT;
            else if (g_ff)           state_in = ttacc_pkg::ST_RDONE;
            else                     state_in = ttacc_pkg::ST_NSQ;
         end
         ttacc_pkg::ST_NSQRT: begin
            if (sqrt_rsp.done) state_in = ttacc_pkg::ST_NDGO;
         end
         ttacc_pkg::ST_NDGO: state_in = ttacc_pkg::ST_NDIV;
         ttacc_pkg::ST_NDIV: begin
            if (div_rsp.done) begin
               priority if (a_ff != 2'd2) state_in = ttacc_pkg::ST_NDGO;
               else if (g_ff)             state_in = ttacc_pkg::ST_RDONE;
               else                       state_in = ttacc_pkg::ST_NSQ;
            end
         end
         ttacc_pkg::ST_RDONE: state_in = ttacc_pkg::ST_IDLE;
         default: state_in = ttacc_pkg::ST_IDLE;
      endcase
   end

   // --- control outputs ---
   always_comb begin
      busy       = state_ff != ttacc_pkg::ST_IDLE;
      mem_rd_en  = 1'b0;
      mem_wr_en  = 1'b0;
      rd_addr    = idx_ff;
      div_start  = 1'b0;
      sqrt_start = 1'b0;
      div_num    = ttacc_pkg::NUM_W'({diff_mag, {ttacc_pkg::DIV_SHIFT{1'b0}}})
                 + ttacc_pkg::NUM_W'(det_mag >> 1);
      div_den    = det_mag;
      mul_a      = '0;
      mul_b      = '0;
      unique case (state_ff)
         ttacc_pkg::ST_TMUL1: begin
            priority if (t_ff == 3'd0) begin
               mul_a = ttacc_pkg::MUL_W'(dv1_ff);
               mul_b = ttacc_pkg::MUL_W'(du2_ff);
            end else if (t_ff < 3'd4) begin
               mul_a = ttacc_pkg::MUL_W'(e2_ff[ax]);
               mul_b = ttacc_pkg::MUL_W'(dv1_ff);
            end else begin
               mul_a = ttacc_pkg::MUL_W'(e2_ff[ax]);
               mul_b = ttacc_pkg::MUL_W'(du1_ff);
            end
         end
         ttacc_pkg::ST_TMUL2: begin
            priority if (t_ff == 3'd0) begin
               mul_a = ttacc_pkg::MUL_W'(du1_ff);
               mul_b = ttacc_pkg::MUL_W'(dv2_ff);
            end else if (t_ff < 3'd4) begin
               mul_a = ttacc_pkg::MUL_W'(e1_ff[ax]);
               mul_b = ttacc_pkg::MUL_W'(dv2_ff);
            end else begin
               mul_a = ttacc_pkg::MUL_W'(e1_ff[ax]);
               mul_b = ttacc_pkg::MUL_W'(du2_ff);
            end
         end
         ttacc_pkg::ST_TSUB: div_start = t_ff != 3'd0;
         ttacc_pkg::ST_ARD: begin
            mem_rd_en = 1'b1;
            rd_addr   = corner_ff[k_ff];
         end
         ttacc_pkg::ST_AWR: mem_wr_en = 1'b1;
         ttacc_pkg::ST_RRD: mem_rd_en = 1'b1;
         ttacc_pkg::ST_NSQ: begin
            mul_a = $signed({1'b0, sq_mag});
            mul_b = $signed({1'b0, sq_mag});
         end
         ttacc_pkg::ST_NCHK: sqrt_start = s_ff != '0;
         ttacc_pkg::ST_NDGO: begin
            div_start = 1'b1;
            div_num   = ttacc_pkg::NUM_W'({nv_mag, {ttacc_pkg::UNIT_SHIFT{1'b0}}})
                      + ttacc_pkg::NUM_W'(r_ff >> 1);
            div_den   = ttacc_pkg::DEN_W'(r_ff);
         end
         default: begin
         end
      endcase
   end

   // --- control registers ---
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttacc_pkg::ST_IDLE;
         cnt_ff       <= 2'd0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= state_ff == ttacc_pkg::ST_TDONE || state_ff == ttacc_pkg::ST_RDONE;
         if (accept && req_opcode == ttacc_pkg::OP_CLEAR) begin
            valid_ff[req_vertex_index] <= 1'b0;
         end
         if (accept && req_opcode == ttacc_pkg::OP_ADD) begin
            cnt_ff <= (cnt_ff == 2'd2) ? 2'd0 : cnt_ff + 2'd1;
         end
         if (mem_wr_en) begin
            valid_ff[corner_ff[k_ff]] <= 1'b1;
         end
      end
   end

   // --- entry memory ---
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[corner_ff[k_ff]] <= acc_word;
      end
      if (mem_rd_en) begin
         rdata_ff  <= mem[rd_addr];
         rvalid_ff <= valid_ff[rd_addr];
      end
   end

   // --- payload registers ---
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      unique case (state_ff)
         ttacc_pkg::ST_IDLE: begin
            if (accept && req_opcode == ttacc_pkg::OP_READ) begin
               idx_ff <= req_vertex_index;
            end
            if (accept && req_opcode == ttacc_pkg::OP_ADD && cnt_ff != 2'd2) begin
               held_pos_ff[cnt_ff[0]][0] <= req_pos_x;
               held_pos_ff[cnt_ff[0]][1] <= req_pos_y;
               held_pos_ff[cnt_ff[0]][2] <= req_pos_z;
               held_tex_ff[cnt_ff[0]][0] <= req_tex_u;
               held_tex_ff[cnt_ff[0]][1] <= req_tex_v;
               held_idx_ff[cnt_ff[0]]    <= req_vertex_index;
            end
            if (accept && req_opcode == ttacc_pkg::OP_ADD && cnt_ff == 2'd2) begin
               e1_ff[0] <= DW'(held_pos_ff[1][0]) - DW'(held_pos_ff[0][0]);
               e1_ff[1] <= DW'(held_pos_ff[1][1]) - DW'(held_pos_ff[0][1]);
               e1_ff[2] <= DW'(held_pos_ff[1][2]) - DW'(held_pos_ff[0][2]);
               e2_ff[0] <= DW'(req_pos_x) - DW'(held_pos_ff[0][0]);
               e2_ff[1] <= DW'(req_pos_y) - DW'(held_pos_ff[0][1]);
               e2_ff[2] <= DW'(req_pos_z) - DW'(held_pos_ff[0][2]);
               du1_ff   <= DW'(held_tex_ff[1][0]) - DW'(held_tex_ff[0][0]);
               dv1_ff   <= DW'(held_tex_ff[1][1]) - DW'(held_tex_ff[0][1]);
               du2_ff   <= DW'(req_tex_u) - DW'(held_tex_ff[0][0]);
               dv2_ff   <= DW'(req_tex_v) - DW'(held_tex_ff[0][1]);
               corner_ff[0] <= held_idx_ff[0];
               corner_ff[1] <= held_idx_ff[1];
               corner_ff[2] <= req_vertex_index;
               t_ff     <= 3'd0;
               sat_ff   <= 1'b0;
               degen_ff <= 1'b0;
            end
         end
         ttacc_pkg::ST_TMUL2: first_ff <= prod_ff;
         ttacc_pkg::ST_TSUB: begin
            if (t_ff == 3'd0) begin
               det_ff   <= diff;
               degen_ff <= diff == '0;
               t_ff     <= 3'd1;
            end else begin
               neg_ff <= diff[ttacc_pkg::TERM_W-1] ^ det_ff[ttacc_pkg::TERM_W-1];
            end
         end
         ttacc_pkg::ST_TDIV: begin
            if (div_rsp.done) begin
               q_ff[t_ff - 3'd1] <= tri_q;
               sat_ff <= sat_ff | tri_clip;
               t_ff   <= t_ff + 3'd1;
               k_ff   <= 2'd0;
            end
         end
         ttacc_pkg::ST_AWR: begin
            sat_ff <= sat_ff | (|acc_clip);
            k_ff   <= k_ff + 2'd1;
         end
         ttacc_pkg::ST_TDONE: begin
            rsp_kind_ff  <= ttacc_pkg::KIND_STATUS;
            rsp_index_ff <= corner_ff[0];
            rsp_degen_ff <= degen_ff;
            rsp_sat_ff   <= sat_ff;
            for (int s = 0; s < ttacc_pkg::NVEC; s++) rsp_vec_ff[s] <= '0;
         end
         ttacc_pkg::ST_RLOAD: begin
            for (int s = 0; s < ttacc_pkg::NVEC; s++) begin
               v_ff[s] <= rvalid_ff ? $signed(rdata_ff[s*AW +: AW]) : '0;
            end
            g_ff <= 1'b0;
            j_ff <= 2'd0;
            s_ff <= '0;
         end
         ttacc_pkg::ST_NSQ: begin
            if (j_ff != 2'd0) s_ff <= s_ff + ttacc_pkg::SUM_W'(prod_ff);
            j_ff <= j_ff + 2'd1;
         end
         ttacc_pkg::ST_NCHK: begin
            a_ff <= 2'd0;
            if (s_ff == '0) begin
               for (int s = 0; s < 3; s++) nout_ff[(g_ff ? 3 : 0) + s] <= '0;
               g_ff <= 1'b1;
               j_ff <= 2'd0;
            end
         end
         ttacc_pkg::ST_NSQRT: begin
            if (sqrt_rsp.done) r_ff <= sqrt_rsp.root;
         end
         ttacc_pkg::ST_NDIV: begin
            if (div_rsp.done) begin
               nout_ff[nsel] <= norm_q;
               a_ff <= a_ff + 2'd1;
               if (a_ff == 2'd2) begin
                  g_ff <= 1'b1;
                  j_ff <= 2'd0;
                  s_ff <= '0;
               end
            end
         end
         ttacc_pkg::ST_RDONE: begin
            rsp_kind_ff  <= ttacc_pkg::KIND_READ;
            rsp_index_ff <= idx_ff;
            rsp_degen_ff <= 1'b0;
            rsp_sat_ff   <= 1'b0;
            for (int s = 0; s < ttacc_pkg::NVEC; s++) rsp_vec_ff[s] <= nout_ff[s];
         end
         default: begin
         end
      endcase
   end

   ttacc_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .rsp   (div_rsp)
   );

   ttacc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ({s_ff, {ttacc_pkg::SQRT_SHIFT{1'b0}}}),
      .rsp      (sqrt_rsp)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_out_index   = rsp_index_ff;
   assign rsp_tangent_x   = rsp_vec_ff[0];
   assign rsp_tangent_y   = rsp_vec_ff[1];
   assign rsp_tangent_z   = rsp_vec_ff[2];
   assign rsp_bitangent_x = rsp_vec_ff[3];
   assign rsp_bitangent_y = rsp_vec_ff[4];
   assign rsp_bitangent_z = rsp_vec_ff[5];
   assign rsp_degenerate  = rsp_degen_ff;
   assign rsp_saturated   = rsp_sat_ff;

   `TTACC_ASSERT_NEXT(a_single_strobe, rsp_valid, !rsp_valid)
   `TTACC_ASSERT_NEXT(a_read_busy, accept && req_opcode == ttacc_pkg::OP_READ, busy)
   `TTACC_ASSERT_NEXT(a_clear_quick, accept && req_opcode == ttacc_pkg::OP_CLEAR, !busy)
   `TTACC_ASSERT_SAME(a_read_flags, rsp_valid && rsp_result_kind, !rsp_degenerate && !rsp_saturated)
endmodule

// File: sv/ttacc_divider.sv
// ----------------------------------------------------------------------------
// Tangent accumulator divider
// Restoring divider, one quotient bit per cycle, with early overflow flag.
// ----------------------------------------------------------------------------
module ttacc_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [ttacc_pkg::NUM_W-1:0]      num,
   input  logic [ttacc_pkg::DEN_W-1:0]      den,
   output ttacc_pkg::div_rsp_type           rsp
);
   localparam int CNT_W = $clog2(ttacc_pkg::Q_W + 1);
   localparam int SH_W  = ttacc_pkg::DEN_W + ttacc_pkg::Q_W;

   logic                          run_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic                          ovf_ff;
   logic [ttacc_pkg::DEN_W-1:0]   rem_ff;
   logic [ttacc_pkg::DEN_W-1:0]   den_ff;
   logic [ttacc_pkg::Q_W-1:0]     quot_ff;
   logic                          ovf_in;
   logic [ttacc_pkg::DEN_W:0]     trial;
   logic [ttacc_pkg::DEN_W:0]     trial_sub;
   logic                          fits;

   assign ovf_in    = SH_W'(num) >= {den, {ttacc_pkg::Q_W{1'b0}}};
   assign trial     = {rem_ff, quot_ff[ttacc_pkg::Q_W-1]};
   assign fits      = trial >= {1'b0, den_ff};
   assign trial_sub = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         run_ff <= 1'b1;
         cnt_ff <= ovf_in ? '0 : CNT_W'(ttacc_pkg::Q_W);
      end else if (run_ff) begin
         if (cnt_ff == '0) begin
            run_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff  <= den;
         ovf_ff  <= ovf_in;
         rem_ff  <= ttacc_pkg::DEN_W'(num[ttacc_pkg::NUM_W-1:ttacc_pkg::Q_W]);
         quot_ff <= num[ttacc_pkg::Q_W-1:0];
      end else if (run_ff && cnt_ff != '0) begin
         rem_ff  <= fits ? trial_sub[ttacc_pkg::DEN_W-1:0] : trial[ttacc_pkg::DEN_W-1:0];
         quot_ff <= {quot_ff[ttacc_pkg::Q_W-2:0], fits};
      end
   end

   assign rsp.done = run_ff && (cnt_ff == '0);
   assign rsp.ovf  = ovf_ff;
   assign rsp.q    = quot_ff;
endmodule

// File: sv/ttacc_sqrt.sv
// ----------------------------------------------------------------------------
// Tangent accumulator square root
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ttacc_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ttacc_pkg::RAD_W-1:0]    radicand,
   output ttacc_pkg::sqrt_rsp_type        rsp
);
   localparam int BIG_W = ttacc_pkg::RAD_W + 1;
   localparam logic [BIG_W-1:0] BIT_TOP = BIG_W'(1) << (ttacc_pkg::RAD_W - 2);

   logic             run_ff;
   logic [BIG_W-1:0] n_ff;
   logic [BIG_W-1:0] res_ff;
   logic [BIG_W-1:0] bit_ff;
   logic [BIG_W-1:0] trial;

   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else if (start) begin
         run_ff <= 1'b1;
      end else if (run_ff && bit_ff == '0) begin
         run_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         n_ff   <= BIG_W'(radicand);
         res_ff <= '0;
         bit_ff <= BIT_TOP;
      end else if (run_ff && bit_ff != '0) begin
         if (n_ff >= trial) begin
            n_ff   <= n_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign rsp.done = run_ff && (bit_ff == '0);
   assign rsp.root = res_ff[ttacc_pkg::ROOT_W-1:0];
endmodule
